// ===== sv/point_in_convex_polygon_area_test_assert.svh =====
// Assertion macros for the polygon area test block.
// Depends on a clk and an arst_n signal in the scope of each use.
`ifndef POINT_IN_CONVEX_POLYGON_AREA_TEST_ASSERT_SVH
`define POINT_IN_CONVEX_POLYGON_AREA_TEST_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define PICA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pica check failed");

// Check that a condition implies another in the next cycle
`define PICA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pica check failed");

`endif

// ===== sv/pica_pkg.sv =====
// Shared constants, codes and types for the polygon area test block.
// No dependencies; used by the interfaces, the accumulator and the top level.
package pica_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MIN_VERTICES = 3;
	localparam int COORD_W      = 16;
	localparam int SLOT_W       = 6;
	localparam int CFG_W        = 7;
	localparam int OUT_W        = 40;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int CROSS_W      = PROD_W + 1;
	localparam int ACC_W        = CROSS_W + CNT_W + 1;
	localparam int CFG_RESET    = 3;

	// Request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TEST  = 1'b1;

	// Control that goes with one polygon segment into the accumulator
	typedef struct packed {
		logic start;
		logic valid;
		logic last;
	} seg_ctl_t;

	// One polygon segment: current vertex i and previous vertex j
	typedef struct packed {
		logic signed [COORD_W-1:0] xi;
		logic signed [COORD_W-1:0] yi;
		logic signed [COORD_W-1:0] xj;
		logic signed [COORD_W-1:0] yj;
	} seg_t;

endpackage

// ===== sv/pica_if.sv =====
// Valid/ready channel interfaces for request and result words.
// Depends on pica_pkg for field widths.
interface pica_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic [pica_pkg::SLOT_W-1:0]          vertex_index;
	logic signed [pica_pkg::COORD_W-1:0]  coord_x;
	logic signed [pica_pkg::COORD_W-1:0]  coord_y;

	modport source (output valid, req_type, vertex_index, coord_x, coord_y, input ready);
	modport sink (input valid, req_type, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pica_res_if;
	logic                         valid;
	logic                         ready;
	logic                         inside_res;
	logic [pica_pkg::OUT_W-1:0]   polygon_twice_area;
	logic [pica_pkg::OUT_W-1:0]   triangle_twice_sum;

	modport source (output valid, inside_res, polygon_twice_area, triangle_twice_sum,
		input ready);
	modport sink (input valid, inside_res, polygon_twice_area, triangle_twice_sum,
		output ready);
endinterface

// ===== sv/pica_accum.sv =====
// Segment pipeline: products, cross terms and the two twice-area accumulators.
// Depends on pica_pkg; fed one segment per cycle by the top level.
module pica_accum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pica_pkg::seg_ctl_t                   ctl,
	input  pica_pkg::seg_t                       seg,
	input  logic signed [pica_pkg::COORD_W-1:0]  px,
	input  logic signed [pica_pkg::COORD_W-1:0]  py,
	output logic                                 fin,
	output logic                                 hit,
	output logic [pica_pkg::OUT_W-1:0]           poly_area,
	output logic [pica_pkg::OUT_W-1:0]           tri_sum
);

	logic signed [pica_pkg::DIFF_W-1:0]  dxi, dyi, dxj, dyj, sh_sum, sh_dif;
	logic signed [pica_pkg::PROD_W-1:0]  p_sh_s2, p_a_s2, p_b_s2;
	logic                                vld_s2, last_s2;
	logic signed [pica_pkg::CROSS_W-1:0] cr;
	logic [pica_pkg::CROSS_W-1:0]        cr_abs_s3;
	logic signed [pica_pkg::PROD_W-1:0]  p_sh_s3;
	logic                                vld_s3, last_s3;
	logic signed [pica_pkg::ACC_W-1:0]   acc_poly_q;
	logic [pica_pkg::ACC_W-1:0]          acc_tri_q;
	logic                                last_s4;
	logic [pica_pkg::ACC_W-1:0]          poly_abs;
	logic                                fin_q, hit_q;
	logic [pica_pkg::OUT_W-1:0]          poly_q, tri_q;

	// Form coordinate differences relative to the query point and the shoelace terms
	always_comb begin
		dxi    = pica_pkg::DIFF_W'(seg.xi) - pica_pkg::DIFF_W'(px);
		dyi    = pica_pkg::DIFF_W'(seg.yi) - pica_pkg::DIFF_W'(py);
		dxj    = pica_pkg::DIFF_W'(seg.xj) - pica_pkg::DIFF_W'(px);
		dyj    = pica_pkg::DIFF_W'(seg.yj) - pica_pkg::DIFF_W'(py);
		sh_sum = pica_pkg::DIFF_W'(seg.xj) + pica_pkg::DIFF_W'(seg.xi);
		sh_dif = pica_pkg::DIFF_W'(seg.yj) - pica_pkg::DIFF_W'(seg.yi);
	end

	// Stage 2: register the three products
	always_ff @(posedge clk) begin
		p_sh_s2 <= pica_pkg::PROD_W'(sh_sum) * pica_pkg::PROD_W'(sh_dif);
		p_a_s2  <= pica_pkg::PROD_W'(dxi) * pica_pkg::PROD_W'(dyj);
		p_b_s2  <= pica_pkg::PROD_W'(dxj) * pica_pkg::PROD_W'(dyi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s2  <= ctl.valid;
			last_s2 <= ctl.valid && ctl.last;
		end
	end

	// Stage 3: cross product and its magnitude
	assign cr = pica_pkg::CROSS_W'(p_a_s2) - pica_pkg::CROSS_W'(p_b_s2);

	always_ff @(posedge clk) begin
		cr_abs_s3 <= cr[pica_pkg::CROSS_W-1] ? -cr : cr;
		p_sh_s3   <= p_sh_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			vld_s3  <= vld_s2;
			last_s3 <= last_s2;
		end
	end

	// Stage 4: clear on a new query, accumulate each segment
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_poly_q <= '0;
			acc_tri_q  <= '0;
		end else if (vld_s3) begin
			acc_poly_q <= acc_poly_q + pica_pkg::ACC_W'(p_sh_s3);
			acc_tri_q  <= acc_tri_q + pica_pkg::ACC_W'(cr_abs_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_s4 <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			last_s4 <= last_s3;
			fin_q   <= last_s4;
		end
	end

	// Stage 5: polygon magnitude, compare, hold the result
	assign poly_abs = acc_poly_q[pica_pkg::ACC_W-1] ? -acc_poly_q : acc_poly_q;

	always_ff @(posedge clk) begin
		if (last_s4) begin
			hit_q  <= (poly_abs == acc_tri_q);
			poly_q <= pica_pkg::OUT_W'(poly_abs);
			tri_q  <= pica_pkg::OUT_W'(acc_tri_q);
		end
	end

	assign fin       = fin_q;
	assign hit       = hit_q;
	assign poly_area = poly_q;
	assign tri_sum   = tri_q;

endmodule

// ===== sv/point_in_convex_polygon_area_test.sv =====
// Point-in-convex-polygon test by triangle twice-area sums over a vertex memory.
// A test walks vertex_count + 1 memory reads, one per cycle, then a four-stage
// multiply/accumulate pipeline into the output register; the next word is taken once
// the result is loaded, and a stalled result holds the next word.
// arst_n clears control state and sets vertex_count to 3; vertex memory is not cleared.
module point_in_convex_polygon_area_test (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [pica_pkg::CFG_W-1:0]     cfg_wdata,
	pica_req_if.sink                       req,
	pica_res_if.source                     res
);

	`include "point_in_convex_polygon_area_test_assert.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam int CMP_W = (pica_pkg::CNT_W > pica_pkg::CFG_W) ?
		pica_pkg::CNT_W : pica_pkg::CFG_W;

	logic [1:0]                           state_q;
	logic [pica_pkg::CFG_W-1:0]           cfg_q;
	logic [CMP_W-1:0]                     cfg_ext;
	logic [pica_pkg::CNT_W-1:0]           n_sel, n_q, k_q;
	logic signed [pica_pkg::COORD_W-1:0]  px_q, py_q;
	logic signed [pica_pkg::COORD_W-1:0]  mem_x [pica_pkg::MAX_VERTICES];
	logic signed [pica_pkg::COORD_W-1:0]  mem_y [pica_pkg::MAX_VERTICES];
	logic signed [pica_pkg::COORD_W-1:0]  rd_x_s1, rd_y_s1, prev_x_q, prev_y_q;
	logic                                 rd_vld_s1, rd_first_s1, rd_last_s1;
	logic [pica_pkg::IDX_W-1:0]           rd_addr, wr_addr;
	logic                                 accept, test_acc, mem_we, rd_en, res_load;
	pica_pkg::seg_ctl_t                   seg_ctl;
	pica_pkg::seg_t                       seg;
	logic                                 fin, hit;
	logic [pica_pkg::OUT_W-1:0]           poly_area, tri_sum;
	logic                                 res_valid_q, hit_q;
	logic [pica_pkg::OUT_W-1:0]           poly_q, tri_q;

	// Accept words only while no test is running
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign test_acc  = accept && (req.req_type == pica_pkg::REQ_TEST);
	assign mem_we    = accept && (req.req_type == pica_pkg::REQ_WRITE) &&
		(32'(req.vertex_index) < pica_pkg::MAX_VERTICES);
	assign wr_addr   = pica_pkg::IDX_W'(req.vertex_index);

	// Hold the vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pica_pkg::CFG_W'(pica_pkg::CFG_RESET);
		end else if (cfg_wen) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Clamp the count to the supported range
	always_comb begin
		cfg_ext = CMP_W'(cfg_q);
		if (cfg_ext < CMP_W'(pica_pkg::MIN_VERTICES)) begin
			n_sel = pica_pkg::CNT_W'(pica_pkg::MIN_VERTICES);
		end else if (cfg_ext > CMP_W'(pica_pkg::MAX_VERTICES)) begin
			n_sel = pica_pkg::CNT_W'(pica_pkg::MAX_VERTICES);
		end else begin
			n_sel = pica_pkg::CNT_W'(cfg_ext);
		end
	end

	// Read the last vertex first, then vertices 0 to n-1
	assign rd_en   = (state_q == ST_RUN) && (k_q <= n_q);
	assign rd_addr = (k_q == '0) ? pica_pkg::IDX_W'(n_q - pica_pkg::CNT_W'(1)) :
		pica_pkg::IDX_W'(k_q - pica_pkg::CNT_W'(1));
	assign res_load = (state_q == ST_FIN) && (!res_valid_q || res.ready);

	// Sequence the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (test_acc) begin
						state_q <= ST_RUN;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (rd_en) begin
						k_q <= k_q + pica_pkg::CNT_W'(1);
					end
					if (fin) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the query point and count
	always_ff @(posedge clk) begin
		if (test_acc) begin
			px_q <= req.coord_x;
			py_q <= req.coord_y;
			n_q  <= n_sel;
		end
	end

	// Vertex memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_x[wr_addr] <= req.coord_x;
			mem_y[wr_addr] <= req.coord_y;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_x_s1 <= mem_x[rd_addr];
			rd_y_s1 <= mem_y[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			rd_vld_s1   <= rd_en;
			rd_first_s1 <= (k_q == '0);
			rd_last_s1  <= (k_q == n_q);
		end
	end

	// Keep the previous vertex to form each segment
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			prev_x_q <= rd_x_s1;
			prev_y_q <= rd_y_s1;
		end
	end

	assign seg_ctl.start = test_acc;
	assign seg_ctl.valid = rd_vld_s1 && !rd_first_s1;
	assign seg_ctl.last  = rd_last_s1;
	assign seg.xi        = rd_x_s1;
	assign seg.yi        = rd_y_s1;
	assign seg.xj        = prev_x_q;
	assign seg.yj        = prev_y_q;

	pica_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (seg_ctl),
		.seg       (seg),
		.px        (px_q),
		.py        (py_q),
		.fin       (fin),
		.hit       (hit),
		.poly_area (poly_area),
		.tri_sum   (tri_sum)
	);

	// Output register: load a finished result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			hit_q  <= hit;
			poly_q <= poly_area;
			tri_q  <= tri_sum;
		end
	end

	assign res.valid              = res_valid_q;
	assign res.inside_res         = hit_q;
	assign res.polygon_twice_area = poly_q;
	assign res.triangle_twice_sum = tri_q;

	// Checks on the sequencer
	`PICA_ASSERT_NEXT(a_test_starts_walk, test_acc, (state_q == ST_RUN) && (k_q == '0))
	`PICA_ASSERT_NOW(a_fin_only_in_run, fin, state_q == ST_RUN)
	`PICA_ASSERT_NOW(a_no_write_in_walk, mem_we, state_q == ST_IDLE)
	`PICA_ASSERT_NOW(a_read_in_range, rd_en, k_q <= n_q)
	`PICA_ASSERT_NEXT(a_load_sets_valid, res_load, res_valid_q && (state_q == ST_IDLE))

endmodule
